// File: rtl/core/world_to_screen_projection_unit_defines.svh
// ---------------------------------------------------------------------------
// World-to-screen projection unit: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef WORLD_TO_SCREEN_PROJECTION_UNIT_DEFINES_SVH
`define WORLD_TO_SCREEN_PROJECTION_UNIT_DEFINES_SVH

// Same-cycle or delayed implication, the property text is given whole.
`define WSP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("wsp assertion failed");

// Next-cycle implication.
`define WSP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wsp next-cycle assertion failed");

`endif

// File: rtl/core/wsp_pkg.sv
// ---------------------------------------------------------------------------
// wsp_pkg
// Widths, register codes and stage types of the projection unit.
// ---------------------------------------------------------------------------
package wsp_pkg;

	localparam int POS_W    = 32;
	localparam int COEF_W   = 32;
	localparam int PROD_W   = POS_W + COEF_W;
	localparam int FRAC_SH  = 12;
	localparam int TERM_W   = PROD_W - FRAC_SH;   // floored product
	localparam int PART_W   = TERM_W + 1;         // sum of two terms
	localparam int SUM_W    = PART_W + 1;         // x, y, w
	localparam int N_W      = SUM_W + 1;          // w +/- x
	localparam int DIV_W    = SUM_W;              // w as unsigned divisor
	localparam int REM_W    = DIV_W;
	localparam int INT_Q_W  = 25;                 // integer quotient bits
	localparam int FRAC_Q_W = 24;
	localparam int Q_W      = INT_Q_W + FRAC_Q_W;
	localparam int DIM_W    = 15;
	localparam int MUL_W    = DIM_W + Q_W;
	localparam int OUT_SH   = 17;
	localparam int M_W      = MUL_W - OUT_SH;
	localparam int OUT_W    = 32;
	localparam int CFG_W    = 64;
	localparam int REG_IDX_W = 3;

	localparam logic signed [SUM_W-1:0] VIS_MIN = SUM_W'(1660945);
	localparam logic [M_W-1:0] SAT_MAG = M_W'(1) << 40;
	localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(1920);
	localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(1080);

	// lane: magnitude stage, saturation stage, quotient bits, multiply, clamp
	localparam int LANE_LAT  = 2 + Q_W + 2;
	// dot product (3), numerator stage (1), lane, output register (1)
	localparam int TOTAL_LAT = 3 + 1 + LANE_LAT + 1;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_RIGHT_LO  = 3'd0,
		REG_RIGHT_HI  = 3'd1,
		REG_UP_LO     = 3'd2,
		REG_UP_HI     = 3'd3,
		REG_DEPTH_LO  = 3'd4,
		REG_DEPTH_HI  = 3'd5,
		REG_WIDTH     = 3'd6,
		REG_HEIGHT    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic valid;
		logic vis;
	} ctl_t;

	typedef struct packed {
		logic [REM_W-1:0]   rem;
		logic [Q_W-1:0]     quo;
		logic [INT_Q_W-1:0] low;
		logic [DIV_W-1:0]   w;
		logic               neg;
		logic               sat;
	} div_t;

endpackage

// File: rtl/core/wsp_dot.sv
// ---------------------------------------------------------------------------
// wsp_dot
// Three-stage row dot product: products, pair sums, final sum (Q.24).
// ---------------------------------------------------------------------------
module wsp_dot (
	input  logic                                 clk,
	input  logic signed [wsp_pkg::POS_W-1:0]     pos_x,
	input  logic signed [wsp_pkg::POS_W-1:0]     pos_y,
	input  logic signed [wsp_pkg::POS_W-1:0]     pos_z,
	input  logic signed [wsp_pkg::COEF_W-1:0]    coef_x,
	input  logic signed [wsp_pkg::COEF_W-1:0]    coef_y,
	input  logic signed [wsp_pkg::COEF_W-1:0]    coef_z,
	input  logic signed [wsp_pkg::COEF_W-1:0]    offset,
	output logic signed [wsp_pkg::SUM_W-1:0]     sum
);
	import wsp_pkg::*;

	logic signed [PROD_W-1:0] px_s1, py_s1, pz_s1;
	logic signed [PART_W-1:0] a_s2, b_s2;
	logic signed [SUM_W-1:0]  sum_s3;
	logic signed [TERM_W-1:0] tx, ty, tz;

	// floor shift: arithmetic right shift drops the low bits, the cast trims the top
	assign tx = TERM_W'(px_s1 >>> FRAC_SH);
	assign ty = TERM_W'(py_s1 >>> FRAC_SH);
	assign tz = TERM_W'(pz_s1 >>> FRAC_SH);

	always_ff @(posedge clk) begin
		px_s1  <= PROD_W'(coef_x) * PROD_W'(pos_x);
		py_s1  <= PROD_W'(coef_y) * PROD_W'(pos_y);
		pz_s1  <= PROD_W'(coef_z) * PROD_W'(pos_z);
		a_s2   <= PART_W'(tx) + PART_W'(ty);
		b_s2   <= PART_W'(tz) + PART_W'(offset);
		sum_s3 <= SUM_W'(a_s2) + SUM_W'(b_s2);
	end

	assign sum = sum_s3;

endmodule

// File: rtl/core/wsp_scale.sv
// ---------------------------------------------------------------------------
// wsp_scale
// One screen-axis lane: |n|/w by restoring division one bit per stage,
// scaled by the screen size, truncated toward zero and saturated.
// ---------------------------------------------------------------------------
module wsp_scale (
	input  logic                                clk,
	input  logic signed [wsp_pkg::N_W-1:0]      num,
	input  logic        [wsp_pkg::DIV_W-1:0]    den,
	input  logic        [wsp_pkg::DIM_W-1:0]    dim,
	output logic signed [wsp_pkg::OUT_W-1:0]    res
);
	import wsp_pkg::*;

	logic [N_W-1:0]   mag_s1;
	logic             neg_s1;
	logic [DIV_W-1:0] w_s1;
	div_t             div_s [Q_W+1];
	logic [M_W-1:0]   m_s3;
	logic             neg_s3, sat_s3;
	logic [OUT_W-1:0] res_s4;
	logic [N_W-1:0]   num_mag;
	logic [N_W-INT_Q_W-1:0] head;
	logic [MUL_W-1:0] prod;

	assign num_mag = num[N_W-1] ? N_W'(-num) : N_W'(num);
	assign head    = mag_s1[N_W-1:INT_Q_W];

	always_ff @(posedge clk) begin
		mag_s1 <= num_mag;
		neg_s1 <= num[N_W-1];
		w_s1   <= den;
		// quotient reaching 2^25 saturates
		div_s[0].sat <= REM_W'(head) >= w_s1;
		div_s[0].rem <= REM_W'(head);
		div_s[0].quo <= '0;
		div_s[0].low <= mag_s1[INT_Q_W-1:0];
		div_s[0].w   <= w_s1;
		div_s[0].neg <= neg_s1;
	end

	for (genvar k = 0; k < Q_W; k++) begin : g_bit
		logic [REM_W:0] rem_sh;
		logic           ge;
		assign rem_sh = {div_s[k].rem, div_s[k].low[INT_Q_W-1]};
		assign ge     = rem_sh >= {1'b0, div_s[k].w};
		always_ff @(posedge clk) begin
			div_s[k+1].rem <= ge ? REM_W'(rem_sh - {1'b0, div_s[k].w}) : REM_W'(rem_sh);
			div_s[k+1].quo <= {div_s[k].quo[Q_W-2:0], ge};
			div_s[k+1].low <= {div_s[k].low[INT_Q_W-2:0], 1'b0};
			div_s[k+1].w   <= div_s[k].w;
			div_s[k+1].neg <= div_s[k].neg;
			div_s[k+1].sat <= div_s[k].sat;
		end
	end

	assign prod = MUL_W'(dim) * MUL_W'(div_s[Q_W].quo);

	always_ff @(posedge clk) begin
		m_s3   <= div_s[Q_W].sat ? SAT_MAG : prod[MUL_W-1:OUT_SH];
		neg_s3 <= div_s[Q_W].neg;
		sat_s3 <= div_s[Q_W].sat;
		if (neg_s3) begin
			if (m_s3 > M_W'(33'h0_8000_0000)) res_s4 <= 32'h8000_0000;
			else res_s4 <= OUT_W'(-m_s3[OUT_W-1:0]);
		end else begin
			if (m_s3 > M_W'(32'h7FFF_FFFF)) res_s4 <= 32'h7FFF_FFFF;
			else res_s4 <= m_s3[OUT_W-1:0];
		end
	end

	assign res = res_s4;

	// saturated quotient always lands on a bound
	`include "world_to_screen_projection_unit_defines.svh"
	logic arst_n;
	assign arst_n = 1'b1;
	`WSP_ASSERT_NEXT(a_sat_bound, sat_s3 && !neg_s3, res_s4 == 32'h7FFF_FFFF)
	`WSP_ASSERT_NEXT(a_sat_bound_neg, sat_s3 && neg_s3, res_s4 == 32'h8000_0000)
	`WSP_ASSERT_NEXT(a_neg_sign, neg_s3 && !sat_s3 && m_s3 != '0, res_s4[OUT_W-1])

endmodule

// File: rtl/core/world_to_screen_projection_unit.sv
// ---------------------------------------------------------------------------
// world_to_screen_projection_unit
// Projects world points to screen pixels through a configured view matrix.
// ---------------------------------------------------------------------------
// Pulse start with a point while busy is low (busy never rises: a point may
// enter every clock). Each point yields exactly one result beat, marked by
// done for one cycle; the receiver cannot stall, so take the beat when done
// is high. The depth is dominated by the 49-stage quotient pipeline (one
// quotient bit per stage) of each screen axis.
// Write the matrix rows and screen size only while no point is in flight.
module world_to_screen_projection_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [wsp_pkg::POS_W-1:0]     pos_x,
	input  logic signed [wsp_pkg::POS_W-1:0]     pos_y,
	input  logic signed [wsp_pkg::POS_W-1:0]     pos_z,
	input  logic                                 cfg_we,
	input  logic [wsp_pkg::REG_IDX_W-1:0]        cfg_index,
	input  logic [wsp_pkg::CFG_W-1:0]            cfg_wdata,
	output logic                                 done,
	output logic signed [wsp_pkg::OUT_W-1:0]     screen_x,
	output logic signed [wsp_pkg::OUT_W-1:0]     screen_y,
	output logic                                 visible
);
	import wsp_pkg::*;

	// configuration registers
	logic [CFG_W-1:0] right_lo_q, right_hi_q, up_lo_q, up_hi_q, depth_lo_q, depth_hi_q;
	logic [DIM_W-1:0] width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_lo_q <= '0;
			right_hi_q <= '0;
			up_lo_q    <= '0;
			up_hi_q    <= '0;
			depth_lo_q <= '0;
			depth_hi_q <= '0;
			width_q    <= WIDTH_RST;
			height_q   <= HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_RIGHT_LO: right_lo_q <= cfg_wdata;
				REG_RIGHT_HI: right_hi_q <= cfg_wdata;
				REG_UP_LO:    up_lo_q    <= cfg_wdata;
				REG_UP_HI:    up_hi_q    <= cfg_wdata;
				REG_DEPTH_LO: depth_lo_q <= cfg_wdata;
				REG_DEPTH_HI: depth_hi_q <= cfg_wdata;
				REG_WIDTH:    width_q    <= cfg_wdata[DIM_W-1:0];
				REG_HEIGHT:   height_q   <= cfg_wdata[DIM_W-1:0];
			endcase
		end
	end

	// three dot products run in lockstep, three stages each
	logic signed [SUM_W-1:0] x_sum, y_sum, w_sum;

	wsp_dot u_dot_x (
		.clk(clk), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.coef_x(right_lo_q[63:32]), .coef_y(right_lo_q[31:0]),
		.coef_z(right_hi_q[63:32]), .offset(right_hi_q[31:0]),
		.sum(x_sum)
	);
	wsp_dot u_dot_y (
		.clk(clk), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.coef_x(up_lo_q[63:32]), .coef_y(up_lo_q[31:0]),
		.coef_z(up_hi_q[63:32]), .offset(up_hi_q[31:0]),
		.sum(y_sum)
	);
	wsp_dot u_dot_w (
		.clk(clk), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.coef_x(depth_lo_q[63:32]), .coef_y(depth_lo_q[31:0]),
		.coef_z(depth_hi_q[63:32]), .offset(depth_hi_q[31:0]),
		.sum(w_sum)
	);

	// valid follows the dot-product stages
	logic valid_s1, valid_s2, valid_s3;
	ctl_t ctl_s4;
	ctl_t ctl_s [LANE_LAT];

	// numerators: w + x for the x axis, w - y for the y axis (screen y flips)
	logic signed [N_W-1:0] nx_s4, ny_s4;
	logic [DIV_W-1:0]      w_s4;

	always_ff @(posedge clk) begin
		nx_s4 <= N_W'(w_sum) + N_W'(x_sum);
		ny_s4 <= N_W'(w_sum) - N_W'(y_sum);
		w_s4  <= DIV_W'(w_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			ctl_s4   <= '0;
			for (int i = 0; i < LANE_LAT; i++) ctl_s[i] <= '0;
		end else begin
			valid_s1     <= start;
			valid_s2     <= valid_s1;
			valid_s3     <= valid_s2;
			ctl_s4.valid <= valid_s3;
			ctl_s4.vis   <= w_sum >= VIS_MIN;
			ctl_s[0]     <= ctl_s4;
			for (int i = 1; i < LANE_LAT; i++) ctl_s[i] <= ctl_s[i-1];
		end
	end

	// per-axis divide and scale lanes
	logic signed [OUT_W-1:0] lane_x, lane_y;

	wsp_scale u_scale_x (
		.clk(clk), .num(nx_s4), .den(w_s4), .dim(width_q), .res(lane_x)
	);
	wsp_scale u_scale_y (
		.clk(clk), .num(ny_s4), .den(w_s4), .dim(height_q), .res(lane_y)
	);

	// output beat register; hidden points report zero coordinates
	logic                    done_q, visible_q;
	logic signed [OUT_W-1:0] screen_x_q, screen_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q     <= 1'b0;
			visible_q  <= 1'b0;
			screen_x_q <= '0;
			screen_y_q <= '0;
		end else begin
			done_q     <= ctl_s[LANE_LAT-1].valid;
			visible_q  <= ctl_s[LANE_LAT-1].vis;
			screen_x_q <= ctl_s[LANE_LAT-1].vis ? lane_x : '0;
			screen_y_q <= ctl_s[LANE_LAT-1].vis ? lane_y : '0;
		end
	end

	assign busy     = 1'b0;
	assign done     = done_q;
	assign visible  = visible_q;
	assign screen_x = screen_x_q;
	assign screen_y = screen_y_q;

	`include "world_to_screen_projection_unit_defines.svh"
	`WSP_ASSERT(a_hidden_zero, done_q && !visible_q |-> screen_x_q == '0 && screen_y_q == '0)
	`WSP_ASSERT(a_fixed_latency, start |-> ##TOTAL_LAT done_q)
	`WSP_ASSERT(a_no_spurious, done_q |-> $past(start, TOTAL_LAT))

endmodule
